// ===== design/orf_pkg.sv =====
// ============================================================================
// orf_pkg
// shared types and constants of the overwriting ring fifo
// ============================================================================
`default_nettype none

package orf_pkg;

    localparam int DATA_W = 16;
    localparam int CNT_W  = 7;
    localparam int OFS_W  = 6;

    typedef enum logic [1:0] {
        OP_ENQUEUE = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_PEEK    = 2'd2,
        OP_STATUS  = 2'd3
    } op_t;

    typedef struct packed {
        logic             ok;
        logic             rd_hit;
        logic [CNT_W-1:0] fill_count;
        logic [CNT_W-1:0] free_slots;
        logic             is_empty;
        logic             is_full;
    } status_t;

endpackage

`default_nettype wire

// ===== design/overwriting_ring_fifo.sv =====
// ============================================================================
// overwriting_ring_fifo
// circular fifo of 16-bit words that overwrites the oldest word when full
// ============================================================================
//  channel   handshake               payload
//  request   req_valid / req_stall   op, write_data, peek_offset
//  response  rsp_valid / rsp_stall   ok, read_data, fill_count, free_slots,
//                                    is_empty, is_full
//  config    cfg_we                  cfg_wdata (size in use)
//
//  one request per cycle unless a stalled response blocks; a request is held
//  in an input register, then its response in a register and the slot read port
//  no clearing pass after reset; the queue starts empty with size 64 (or DEPTH)
//  a stalled response holds; the input register then takes one more request
// ============================================================================
`default_nettype none

module overwriting_ring_fifo #(
    parameter int DEPTH = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    output logic                             req_stall,
    input  wire logic [1:0]                  op,
    input  wire logic [orf_pkg::DATA_W-1:0]  write_data,
    input  wire logic [orf_pkg::OFS_W-1:0]   peek_offset,
    input  wire logic                        cfg_we,
    input  wire logic [orf_pkg::CNT_W-1:0]   cfg_wdata,
    output logic                             rsp_valid,
    input  wire logic                        rsp_stall,
    output logic                             ok,
    output logic [orf_pkg::DATA_W-1:0]       read_data,
    output logic [orf_pkg::CNT_W-1:0]        fill_count,
    output logic [orf_pkg::CNT_W-1:0]        free_slots,
    output logic                             is_empty,
    output logic                             is_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                        hold_vld_reg;
    orf_pkg::op_t                hold_op_reg;
    logic [orf_pkg::DATA_W-1:0]  hold_wdata_reg;
    logic [orf_pkg::OFS_W-1:0]   hold_ofs_reg;

    logic                        rsp_vld_reg;
    orf_pkg::status_t            rsp_stat_reg;

    logic                        step;
    logic                        req_take;
    logic                        mem_we;
    logic [PTR_W-1:0]            mem_waddr;
    logic [PTR_W-1:0]            mem_raddr;
    logic [orf_pkg::DATA_W-1:0]  mem_rdata;
    orf_pkg::status_t            stat;

    assign step      = hold_vld_reg & (~rsp_vld_reg | ~rsp_stall);
    assign req_stall = hold_vld_reg & ~step;
    assign req_take  = req_valid & ~req_stall;

    orf_ctrl #(
        .DEPTH (DEPTH),
        .PTR_W (PTR_W)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .step        (step),
        .op          (hold_op_reg),
        .peek_offset (hold_ofs_reg),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_raddr   (mem_raddr),
        .stat        (stat)
    );

    orf_mem #(
        .DEPTH (DEPTH),
        .PTR_W (PTR_W)
    ) u_mem (
        .clk   (clk),
        .we    (step & mem_we),
        .waddr (mem_waddr),
        .wdata (hold_wdata_reg),
        .re    (step & stat.rd_hit),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_vld_reg <= 1'b0;
            rsp_vld_reg  <= 1'b0;
        end
        else
        begin
            if (req_take)
                hold_vld_reg <= 1'b1;
            else if (step)
                hold_vld_reg <= 1'b0;

            if (step)
                rsp_vld_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_vld_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            hold_op_reg    <= orf_pkg::op_t'(op);
            hold_wdata_reg <= write_data;
            hold_ofs_reg   <= peek_offset;
        end
        if (step)
            rsp_stat_reg <= stat;
    end

    assign rsp_valid  = rsp_vld_reg;
    assign ok         = rsp_stat_reg.ok;
    assign read_data  = rsp_stat_reg.rd_hit ? mem_rdata : '0;
    assign fill_count = rsp_stat_reg.fill_count;
    assign free_slots = rsp_stat_reg.free_slots;
    assign is_empty   = rsp_stat_reg.is_empty;
    assign is_full    = rsp_stat_reg.is_full;

endmodule

`default_nettype wire

// ===== design/orf_ctrl.sv =====
// ============================================================================
// orf_ctrl
// pointer, count and size state; decodes one operation per step
// ============================================================================
`default_nettype none

module orf_ctrl #(
    parameter int DEPTH = 64,
    parameter int PTR_W = 6
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [orf_pkg::CNT_W-1:0]   cfg_wdata,
    input  wire logic                        step,
    input  wire orf_pkg::op_t                op,
    input  wire logic [orf_pkg::OFS_W-1:0]   peek_offset,
    output logic                             mem_we,
    output logic [PTR_W-1:0]                 mem_waddr,
    output logic [PTR_W-1:0]                 mem_raddr,
    output orf_pkg::status_t                 stat
);

    localparam int CW       = orf_pkg::CNT_W;
    localparam int AW       = ((PTR_W > CW) ? PTR_W : CW) + 1;
    localparam int SIZE_MAX = (DEPTH < 127) ? DEPTH : 127;
    localparam int SIZE_RST = (DEPTH < 64) ? DEPTH : 64;

    logic [PTR_W-1:0] wp_reg,   wp_next;
    logic [PTR_W-1:0] rp_reg,   rp_next;
    logic [CW-1:0]    cnt_reg,  cnt_next;
    logic [CW-1:0]    size_reg, size_next;

    logic [AW-1:0]    wp_inc;
    logic [AW-1:0]    rp_inc;
    logic [AW-1:0]    peek_sum;
    logic [AW-1:0]    peek_idx;
    logic [PTR_W-1:0] wp_adv;
    logic [PTR_W-1:0] rp_adv;

    // pointer wrap at the size in use
    assign wp_inc   = AW'(wp_reg) + AW'(1);
    assign rp_inc   = AW'(rp_reg) + AW'(1);
    assign wp_adv   = (wp_inc >= AW'(size_reg)) ? '0 : wp_inc[PTR_W-1:0];
    assign rp_adv   = (rp_inc >= AW'(size_reg)) ? '0 : rp_inc[PTR_W-1:0];
    assign peek_sum = AW'(rp_reg) + AW'(peek_offset);
    assign peek_idx = (peek_sum >= AW'(size_reg)) ? (peek_sum - AW'(size_reg)) : peek_sum;

    // size clamp
    always_comb
    begin
        if (cfg_wdata == '0)
            size_next = CW'(1);
        else if (cfg_wdata > CW'(SIZE_MAX))
            size_next = CW'(SIZE_MAX);
        else
            size_next = cfg_wdata;
    end

    always_comb
    begin
        wp_next       = wp_reg;
        rp_next       = rp_reg;
        cnt_next      = cnt_reg;
        mem_we        = 1'b0;
        mem_raddr     = rp_reg;
        stat.ok       = 1'b1;
        stat.rd_hit   = 1'b0;
        case (op)
            orf_pkg::OP_ENQUEUE:
            begin
                mem_we  = 1'b1;
                wp_next = wp_adv;
                if (cnt_reg >= size_reg)
                    rp_next = rp_adv;
                else
                    cnt_next = cnt_reg + CW'(1);
            end
            orf_pkg::OP_DEQUEUE:
            begin
                if (cnt_reg == '0)
                    stat.ok = 1'b0;
                else
                begin
                    stat.rd_hit = 1'b1;
                    rp_next     = rp_adv;
                    cnt_next    = cnt_reg - CW'(1);
                end
            end
            orf_pkg::OP_PEEK:
            begin
                mem_raddr = peek_idx[PTR_W-1:0];
                if (CW'(peek_offset) >= cnt_reg)
                    stat.ok = 1'b0;
                else
                    stat.rd_hit = 1'b1;
            end
            default:
            begin
            end
        endcase
        stat.fill_count = cnt_next;
        stat.free_slots = size_reg - cnt_next;
        stat.is_empty   = (cnt_next == '0);
        stat.is_full    = (cnt_next == size_reg);
    end

    assign mem_waddr = wp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            cnt_reg  <= '0;
            size_reg <= CW'(SIZE_RST);
        end
        else if (cfg_we)
        begin
            // a size write empties the queue
            wp_reg   <= '0;
            rp_reg   <= '0;
            cnt_reg  <= '0;
            size_reg <= size_next;
        end
        else if (step)
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/orf_mem.sv =====
// ============================================================================
// orf_mem
// slot storage, one write and one registered read per cycle
// ============================================================================
`default_nettype none

module orf_mem #(
    parameter int DEPTH = 64,
    parameter int PTR_W = 6
) (
    input  wire logic                         clk,
    input  wire logic                         we,
    input  wire logic [PTR_W-1:0]             waddr,
    input  wire logic [orf_pkg::DATA_W-1:0]   wdata,
    input  wire logic                         re,
    input  wire logic [PTR_W-1:0]             raddr,
    output logic [orf_pkg::DATA_W-1:0]        rdata
);

    logic [orf_pkg::DATA_W-1:0] slot_reg [DEPTH];
    logic [orf_pkg::DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            slot_reg[waddr] <= wdata;
        if (re)
            rdata_reg <= slot_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire
